### src/biquad_iir_filter_defines.svh
// -----------------------------------------------------------------------------
// biquad_iir_filter_defines.svh
// Assertion macros used by the biquad filter control module.
// -----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/biq_pkg.sv
// -----------------------------------------------------------------------------
// biq_pkg
// Types, constants and a helper function for the biquad filter.
// -----------------------------------------------------------------------------
package biq_pkg;

  localparam int COEF_W          = 24;
  localparam int DELAY_W         = 40;
  localparam int ACC_W           = 64;
  localparam int COEF_FRAC_BITS  = 20;
  localparam int Y_SPLIT         = DELAY_W / 2;
  localparam int CFG_ADDR_W      = 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_A2 = 3'd4;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_B0,
    OP_Y,
    OP_N1_BASE,
    OP_FB1_HI,
    OP_FB1_LO,
    OP_N1_SUB,
    OP_FB2_HI,
    OP_FB2_LO,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DELAY_W-1:0] value;
  } sat_t;

  function automatic sat_t sat_delay(input logic signed [ACC_W-1:0] v);
    sat_t s;
    s.hit = !((&v[ACC_W-1:DELAY_W-1]) || !(|v[ACC_W-1:DELAY_W-1]));
    if (s.hit) begin
      s.value = v[ACC_W-1] ? DELAY_MIN : DELAY_MAX;
    end else begin
      s.value = v[DELAY_W-1:0];
    end
    return s;
  endfunction

endpackage

### src/biq_ctrl.sv
// -----------------------------------------------------------------------------
// biq_ctrl
// Sequencer that walks the datapath through the steps of one sample.
// -----------------------------------------------------------------------------
`include "biquad_iir_filter_defines.svh"

module biq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  biq_pkg::status_t status,
  output biq_pkg::cmd_t    cmd
);
  import biq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  op_t    op;
  logic   in_fire;

  assign in_fire  = in_valid && in_ready;
  assign cmd.load = in_fire;
  assign cmd.op   = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_NONE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state    <= ST_RUN;
            op       <= OP_MUL_B0;
            in_ready <= 1'b0;
          end
        end
        ST_RUN: begin
          unique case (op)
            OP_MUL_B0:  op <= OP_Y;
            OP_Y:       op <= OP_N1_BASE;
            OP_N1_BASE: op <= OP_FB1_HI;
            OP_FB1_HI:  op <= OP_FB1_LO;
            OP_FB1_LO:  op <= OP_N1_SUB;
            OP_N1_SUB:  op <= OP_FB2_HI;
            OP_FB2_HI:  op <= OP_FB2_LO;
            OP_FB2_LO:  op <= OP_FINISH;
            OP_FINISH: begin
              // The last step waits until the output register can take the result.
              if (!status.out_blocked) begin
                state    <= ST_IDLE;
                op       <= OP_NONE;
                in_ready <= 1'b1;
              end
            end
            default: begin
              state    <= ST_IDLE;
              op       <= OP_NONE;
              in_ready <= 1'b1;
            end
          endcase
        end
        default: begin
          state    <= ST_IDLE;
          op       <= OP_NONE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `BIQ_ASSERT_NEXT(a_accept_starts, in_fire, (op == OP_MUL_B0) && !in_ready, "accepted sample did not start the sequence")
  `BIQ_ASSERT_SAME(a_ready_only_idle, in_ready, op == OP_NONE, "ready raised while a sample is in progress")
  `BIQ_ASSERT_NEXT(a_finish_holds, (op == OP_FINISH) && status.out_blocked, op == OP_FINISH, "final step left while the output was blocked")
  `BIQ_ASSERT_NEXT(a_finish_frees, (op == OP_FINISH) && !status.out_blocked, in_ready, "input not reopened after the final step")

endmodule

### src/biq_dp.sv
// -----------------------------------------------------------------------------
// biq_dp
// Coefficient registers, shared multiplier, accumulators, delays and output.
// -----------------------------------------------------------------------------
module biq_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [biq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [biq_pkg::COEF_W-1:0]          cfg_data,
  input  biq_pkg::cmd_t                       cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_restart,
  output biq_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      filtered,
  output logic                                clipped
);
  import biq_pkg::*;

  // Multiplier operand B carries either the sample or one half of y.
  localparam int MB = (SAMPLE_WIDTH > Y_SPLIT + 1) ? SAMPLE_WIDTH : Y_SPLIT + 1;
  localparam int PW = COEF_W + MB;
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0]       coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [DELAY_W-1:0]      y, d1, d2;
  logic signed [ACC_W-1:0]        n1, n2, pacc;
  logic signed [PW-1:0]           preg;
  logic signed [SAMPLE_WIDTH-1:0] y_out;
  logic                           hit;

  logic signed [COEF_W-1:0]       mul_a;
  logic signed [MB-1:0]           mul_b;
  logic signed [PW-1:0]           product;
  logic signed [Y_SPLIT-1:0]      y_hi;
  logic signed [Y_SPLIT:0]        y_lo;
  logic signed [ACC_W-1:0]        preg_ext, preg_up, pacc_scaled, y_round;
  sat_t                           sat_y, sat_n1, sat_n2;
  logic                           out_ovf;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;
  logic                           finish_go;

  assign status.out_blocked = out_valid && !out_ready;
  assign finish_go          = (cmd.op == OP_FINISH) && !status.out_blocked;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_B0:  coef_b0 <= cfg_data;
        CFG_B1:  coef_b1 <= cfg_data;
        CFG_B2:  coef_b2 <= cfg_data;
        CFG_A1:  coef_a1 <= cfg_data;
        CFG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The 40-bit y is split so that every product fits one narrow multiplier.
  assign y_hi = y[DELAY_W-1:Y_SPLIT];
  assign y_lo = {1'b0, y[Y_SPLIT-1:0]};

  always_comb begin
    unique case (cmd.op)
      OP_Y:       begin mul_a = coef_b1; mul_b = MB'(x);    end
      OP_N1_BASE: begin mul_a = coef_a1; mul_b = MB'(y_hi); end
      OP_FB1_HI:  begin mul_a = coef_a1; mul_b = MB'(y_lo); end
      OP_FB1_LO:  begin mul_a = coef_b2; mul_b = MB'(x);    end
      OP_N1_SUB:  begin mul_a = coef_a2; mul_b = MB'(y_hi); end
      OP_FB2_HI:  begin mul_a = coef_a2; mul_b = MB'(y_lo); end
      default:    begin mul_a = coef_b0; mul_b = MB'(x);    end
    endcase
  end

  assign product     = mul_a * mul_b;
  assign preg_ext    = ACC_W'(preg);
  assign preg_up     = (preg_ext <<< Y_SPLIT) + ROUND_HALF;
  assign pacc_scaled = pacc >>> COEF_FRAC_BITS;
  assign sat_y       = sat_delay(preg_ext + ACC_W'(d1));
  assign sat_n1      = sat_delay(n1);
  assign sat_n2      = sat_delay(n2 - pacc_scaled);
  assign y_round     = (ACC_W'(y) + ROUND_HALF) >>> COEF_FRAC_BITS;
  assign out_ovf     = !((&y_round[ACC_W-1:SAMPLE_WIDTH-1]) ||
                         !(|y_round[ACC_W-1:SAMPLE_WIDTH-1]));
  assign out_sat     = out_ovf ? (y_round[ACC_W-1] ? SMIN : SMAX)
                               : y_round[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    preg <= product;
    if (cmd.load) begin
      x   <= in_sample;
      hit <= 1'b0;
    end
    unique case (cmd.op)
      OP_Y: begin
        y   <= sat_y.value;
        hit <= sat_y.hit;
      end
      OP_N1_BASE: begin
        n1    <= preg_ext + ACC_W'(d2);
        y_out <= out_sat;
        hit   <= hit | out_ovf;
      end
      OP_FB1_HI: pacc <= preg_up;
      OP_FB1_LO: pacc <= pacc + preg_ext;
      OP_N1_SUB: begin
        n1 <= n1 - pacc_scaled;
        n2 <= preg_ext;
      end
      OP_FB2_HI: begin
        hit  <= hit | sat_n1.hit;
        pacc <= preg_up;
      end
      OP_FB2_LO: pacc <= pacc + preg_ext;
      OP_FINISH: begin
        if (finish_go) begin
          filtered <= y_out;
          clipped  <= hit | sat_n2.hit;
        end
      end
      default: ;
    endcase
  end

  // The delays clear on reset and ahead of a restart transaction.
  always_ff @(posedge clk) begin
    if (rst || (cmd.load && in_restart)) begin
      d1 <= '0;
      d2 <= '0;
    end else begin
      if (cmd.op == OP_FB2_HI) begin
        d1 <= sat_n1.value;
      end
      if (finish_go) begin
        d2 <= sat_n2.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/biquad_iir_filter.sv
// -----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR section, transposed direct form II, in fixed point.
//
// Channel   Direction  Transaction carries
// s_axis    in         sample (tdata), restart (tuser)
// m_axis    out        filtered (tdata), clipped (tuser)
// cfg       in         one coefficient write per cycle with cfg_we high
//
// A sample passes through nine sequenced steps from acceptance to its result
// entering the output register, seven of them on the single shared multiplier.
// A new sample is accepted only after the previous one is through, as ready
// rises again only after the last step.
// A held result stalls the last step only, and the input side stays closed
// while it waits. Reset is synchronous; it restores default coefficients and
// zeroes both delays.
// -----------------------------------------------------------------------------
module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [SW-1:0] sample
  input  logic                                    s_tuser,  // [0] restart
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // [SW-1:0] filtered
  output logic                                    m_tuser,  // [0] clipped
  input  logic                                    cfg_we,
  input  logic [biq_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [biq_pkg::COEF_W-1:0]              cfg_data
);
  import biq_pkg::*;

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cmd_t                           cmd;
  status_t                        status;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  assign in_sample = s_tdata[SAMPLE_WIDTH-1:0];
  assign m_tdata   = DATA_W'($unsigned(filtered));

  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  biq_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .in_sample  (in_sample),
    .in_restart (s_tuser),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .filtered   (filtered),
    .clipped    (m_tuser)
  );

endmodule
